[src/cscl_pkg.sv]
package cscl_pkg;

   localparam int FREQ_W  = 20;
   localparam int SUM_W   = 24;
   localparam int WAIT_W  = 24;
   localparam int PPR_W   = 10;
   localparam int PROD_W  = 2 * FREQ_W;
   localparam int CMP_W   = PROD_W + 6;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 24;

   localparam logic [FREQ_W-1:0] FREQ_MAX = {FREQ_W{1'b1}};
   localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SCALE      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PPR        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SETTLE_CLS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SETTLE_CAL = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_GAP_CAL    = 3'd4;

   // input function codes
   localparam logic [1:0] FUNC_TICK = 2'd0;
   localparam logic [1:0] FUNC_CAL  = 2'd1;
   localparam logic [1:0] FUNC_CLS  = 2'd2;

   // measurement stages (low bits of phase), bit 2 marks calibration
   localparam logic [1:0] STG_GAP    = 2'd0;
   localparam logic [1:0] STG_SETTLE = 2'd1;
   localparam logic [1:0] STG_FIRST  = 2'd2;
   localparam logic [1:0] STG_COUNT  = 2'd3;
   localparam logic [2:0] PH_IDLE    = 3'd0;

   // color classes
   localparam logic [2:0] CLS_RED   = 3'd0;
   localparam logic [2:0] CLS_GREEN = 3'd1;
   localparam logic [2:0] CLS_BLUE  = 3'd2;
   localparam logic [2:0] CLS_BLACK = 3'd3;
   localparam logic [2:0] CLS_WHITE = 3'd4;
   localparam logic [2:0] CLS_UNDET = 3'd5;

   // output word selection
   localparam logic [1:0] OUT_NONE = 2'd0;
   localparam logic [1:0] OUT_CLS  = 2'd1;
   localparam logic [1:0] OUT_CAL  = 2'd2;

   typedef struct packed {
      logic       step;
      logic       div_start;
      logic       store_freq;
      logic       chan;
      logic       mul_en;
      logic       cls_en;
      logic       store_ref;
      logic       load_out;
      logic [1:0] out_sel;
      logic [2:0] idx;
   } cscl_cmd_type;

   typedef struct packed {
      logic need_div;
      logic chan_done;
      logic last_chan;
      logic cal;
      logic cal_last;
      logic div_done;
   } cscl_sts_type;

   function automatic logic [1:0] filter_code(input logic [1:0] fi);
      logic [1:0] c;
      unique case (fi)
         2'd1:    c = 2'd3;
         2'd2:    c = 2'd2;
         default: c = 2'd0;
      endcase
      return c;
   endfunction

   function automatic logic [1:0] scale_code(input logic [1:0] m);
      logic [1:0] c;
      unique case (m)
         2'd0:    c = 2'd2;
         2'd1:    c = 2'd1;
         2'd2:    c = 2'd3;
         default: c = 2'd0;
      endcase
      return c;
   endfunction

endpackage

[src/cscl_div.sv]
module cscl_div #(
   parameter int NW = 37,
   parameter int DW = 24
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic          done,
   output logic [NW-1:0] quo
);
   localparam int CW = $clog2(NW + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [NW-1:0] n_ff, n_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW:0]   trial;
   logic          ge;

   always_comb begin
      trial   = {rem_ff, n_ff[NW-1]};
      ge      = trial >= {1'b0, den};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      n_in    = n_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(NW);
         n_in    = num;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = ge ? DW'(trial - {1'b0, den}) : DW'(trial);
         n_in   = {n_ff[NW-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      n_ff   <= n_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign quo  = n_ff;

endmodule

[src/cscl_dp.sv]
module cscl_dp #(
   parameter int TICK_HZ     = 1000000,
   parameter int CAL_SAMPLES = 5,
   parameter int TICK_WIDTH  = 24
) (
   input  logic                            clock,
   input  logic                            reset,
   input  cscl_pkg::cscl_cmd_type          cmd,
   output cscl_pkg::cscl_sts_type          sts,
   input  logic [1:0]                      req_func,
   input  logic                            req_sensor_level,
   input  logic                            csr_we,
   input  logic [cscl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [cscl_pkg::CSR_DAT_W-1:0]  csr_wdata,
   output logic [1:0]                      rsp_scale_pins,
   output logic [1:0]                      rsp_filter_pins,
   output logic                            rsp_busy_res,
   output logic                            rsp_result_valid,
   output logic                            rsp_result_kind,
   output logic [2:0]                      rsp_color_class,
   output logic [cscl_pkg::FREQ_W-1:0]     rsp_red_freq,
   output logic [cscl_pkg::FREQ_W-1:0]     rsp_green_freq,
   output logic [cscl_pkg::FREQ_W-1:0]     rsp_blue_freq
);
   import cscl_pkg::*;

   localparam longint unsigned NUM_MAX = 64'd1023 * longint'(TICK_HZ);
   localparam int NW   = $clog2(NUM_MAX + 1);
   localparam int DW   = TICK_WIDTH;
   localparam logic [DW-1:0] TICK_MAX = {DW{1'b1}};
   // averaging by reciprocal multiplication, exact for every SUM_W-bit sum
   localparam int AVG_SH = SUM_W + $clog2(CAL_SAMPLES);
   localparam int AVG_PW = 2 * SUM_W + 1;
   localparam longint unsigned AVG_MUL =
      ((64'd1 << AVG_SH) + longint'(CAL_SAMPLES) - 64'd1) / longint'(CAL_SAMPLES);

   // configuration
   logic [1:0]        scale_ff, scale_in;
   logic [PPR_W-1:0]  ppr_ff, ppr_in;
   logic [WAIT_W-1:0] stcls_ff, stcls_in;
   logic [WAIT_W-1:0] stcal_ff, stcal_in;
   logic [WAIT_W-1:0] gap_ff, gap_in;
   logic [NW-1:0]     ppr_hz_ff, ppr_hz_in;

   // measurement state
   logic [2:0]        phase_ff, phase_in;
   logic [1:0]        fi_ff, fi_in;
   logic              last_ff, last_in;
   logic [PPR_W-1:0]  ec_ff, ec_in;
   logic [DW-1:0]     tick_ff, tick_in;
   logic [WAIT_W-1:0] wait_ff, wait_in;
   logic [2:0]        si_ff, si_in;
   logic [SUM_W-1:0]  sums_ff [3];
   logic [SUM_W-1:0]  sums_in [3];
   logic [FREQ_W-1:0] refs_ff [3];
   logic [FREQ_W-1:0] refs_in [3];
   logic [FREQ_W-1:0] rd_ff [3];
   logic [FREQ_W-1:0] rd_in [3];
   logic [PROD_W-1:0] prod_ff [6];
   logic [2:0]        cls_ff, cls_in;

   // output word
   logic [1:0]        o_scale_ff, o_filter_ff;
   logic              o_busy_ff, o_valid_ff, o_kind_ff;
   logic [2:0]        o_cls_ff;
   logic [FREQ_W-1:0] o_res_ff [3];

   logic              cal, rise, idle;
   logic [1:0]        stage, rd_idx;
   logic [PPR_W-1:0]  ec_new;
   logic [WAIT_W-1:0] lim;
   logic [NW-1:0]     div_num, quo;
   logic [DW-1:0]     div_den;
   logic              div_done;
   logic [FREQ_W-1:0] quo_sat;
   logic [SUM_W:0]    sum_w;
   logic [SUM_W-1:0]  avg_src, avg_q;
   logic [AVG_PW-1:0] avg_prod;
   logic [FREQ_W-1:0] avg_ref;
   logic [FREQ_W-1:0] ma, mb;
   logic [CMP_W-1:0]  p0, p1, p2, p3, p4, p5;
   logic              is_red, is_green, is_blue, is_black, is_white;
   logic [FREQ_W+4:0] r10, g10, b10, r9, g9, b9;

   assign cal    = phase_ff[2];
   assign stage  = phase_ff[1:0];
   assign idle   = phase_ff == PH_IDLE;
   assign rise   = req_sensor_level & ~last_ff;
   assign rd_idx = (fi_ff == 2'd3) ? 2'd0 : fi_ff;
   assign ec_new = rise ? ec_ff + 1'b1 : ec_ff;
   assign lim    = cal ? stcal_ff : stcls_ff;

   assign sts.need_div  = !idle && stage == STG_COUNT && ec_new >= ppr_ff;
   assign sts.chan_done = !idle && stage == STG_FIRST && ppr_ff == '0;
   assign sts.last_chan = fi_ff >= 2'd2;
   assign sts.cal       = cal;
   assign sts.cal_last  = ({1'b0, si_ff} + 4'd1) >= 4'(CAL_SAMPLES);
   assign sts.div_done  = div_done;

   assign div_num = ppr_hz_ff;
   assign div_den = tick_ff;

   cscl_div #(.NW(NW), .DW(DW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (quo)
   );

   assign quo_sat = (quo > NW'(FREQ_MAX)) ? FREQ_MAX : FREQ_W'(quo);

   // calibration average of the selected color
   always_comb begin
      avg_src = '0;
      for (int i = 0; i < 3; i++)
         if (cmd.idx == 3'(i)) avg_src = sums_ff[i];
      avg_prod = AVG_PW'(avg_src) * AVG_PW'(AVG_MUL);
      avg_q    = SUM_W'(avg_prod >> AVG_SH);
      if (avg_q == '0)                      avg_ref = FREQ_W'(1);
      else if (avg_q > SUM_W'(FREQ_MAX))    avg_ref = FREQ_MAX;
      else                                  avg_ref = FREQ_W'(avg_q);
   end

   // shared multiplier for the cross products
   always_comb begin
      unique case (cmd.idx)
         3'd0:    begin ma = rd_ff[0]; mb = refs_ff[1]; end
         3'd1:    begin ma = rd_ff[1]; mb = refs_ff[0]; end
         3'd2:    begin ma = rd_ff[0]; mb = refs_ff[2]; end
         3'd3:    begin ma = rd_ff[2]; mb = refs_ff[0]; end
         3'd4:    begin ma = rd_ff[1]; mb = refs_ff[2]; end
         3'd5:    begin ma = rd_ff[2]; mb = refs_ff[1]; end
         default: begin ma = '0; mb = '0; end
      endcase
   end

   always_comb begin
      p0 = CMP_W'(prod_ff[0]);
      p1 = CMP_W'(prod_ff[1]);
      p2 = CMP_W'(prod_ff[2]);
      p3 = CMP_W'(prod_ff[3]);
      p4 = CMP_W'(prod_ff[4]);
      p5 = CMP_W'(prod_ff[5]);
      is_red   = (p0 * 10 > p1 * 20) && (p2 * 10 > p3 * 18);
      is_green = (p1 * 10 > p0 * 16) && (p4 * 10 > p5 * 15);
      is_blue  = (p3 * 10 > p2 * 18) && (p5 * 10 > p4 * 17);
      r10 = (FREQ_W+5)'(rd_ff[0]) * 10;
      g10 = (FREQ_W+5)'(rd_ff[1]) * 10;
      b10 = (FREQ_W+5)'(rd_ff[2]) * 10;
      r9  = (FREQ_W+5)'(refs_ff[0]) * 9;
      g9  = (FREQ_W+5)'(refs_ff[1]) * 9;
      b9  = (FREQ_W+5)'(refs_ff[2]) * 9;
      is_black = r10 < (FREQ_W+5)'(refs_ff[0]) && g10 < (FREQ_W+5)'(refs_ff[1])
              && b10 < (FREQ_W+5)'(refs_ff[2]);
      is_white = r10 > r9 && g10 > g9 && b10 > b9;
      priority if (is_red)   cls_in = CLS_RED;
      else if (is_green)     cls_in = CLS_GREEN;
      else if (is_blue)      cls_in = CLS_BLUE;
      else if (is_black)     cls_in = CLS_BLACK;
      else if (is_white)     cls_in = CLS_WHITE;
      else                   cls_in = CLS_UNDET;
   end

   // configuration writes
   always_comb begin
      scale_in  = scale_ff;
      ppr_in    = ppr_ff;
      stcls_in  = stcls_ff;
      stcal_in  = stcal_ff;
      gap_in    = gap_ff;
      ppr_hz_in = NW'(ppr_ff) * NW'(TICK_HZ);
      if (csr_we) begin
         unique case (csr_index)
            REG_SCALE:      scale_in = csr_wdata[1:0];
            REG_PPR:        ppr_in   = csr_wdata[PPR_W-1:0];
            REG_SETTLE_CLS: stcls_in = csr_wdata;
            REG_SETTLE_CAL: stcal_in = csr_wdata;
            REG_GAP_CAL:    gap_in   = csr_wdata;
            default:        ;
         endcase
      end
   end

   // measurement sequencing
   always_comb begin
      phase_in = phase_ff;
      fi_in    = fi_ff;
      last_in  = last_ff;
      ec_in    = ec_ff;
      tick_in  = tick_ff;
      wait_in  = wait_ff;
      si_in    = si_ff;
      sum_w    = '0;
      for (int i = 0; i < 3; i++) begin
         sums_in[i] = sums_ff[i];
         refs_in[i] = refs_ff[i];
         rd_in[i]   = rd_ff[i];
      end
      if (cmd.step) begin
         last_in = req_sensor_level;
         if (idle) begin
            if (req_func == FUNC_CAL || req_func == FUNC_CLS) begin
               si_in    = '0;
               fi_in    = 2'd0;
               wait_in  = '0;
               phase_in = {req_func == FUNC_CAL, STG_SETTLE};
               if (req_func == FUNC_CAL)
                  for (int i = 0; i < 3; i++) sums_in[i] = '0;
            end
         end else begin
            unique case (stage)
               STG_GAP: begin
                  if (wait_ff >= gap_ff) begin
                     fi_in    = 2'd0;
                     phase_in = {cal, STG_SETTLE};
                     wait_in  = '0;
                  end else begin
                     wait_in = wait_ff + 1'b1;
                  end
               end
               STG_SETTLE: begin
                  if (wait_ff >= lim) phase_in = {cal, STG_FIRST};
                  else wait_in = wait_ff + 1'b1;
               end
               STG_FIRST: begin
                  if (ppr_ff == '0) begin
                     for (int i = 0; i < 3; i++)
                        if (rd_idx == 2'(i)) rd_in[i] = '0;
                  end else if (rise) begin
                     phase_in = {cal, STG_COUNT};
                     ec_in    = '0;
                     tick_in  = '0;
                  end
               end
               default: begin
                  if (tick_ff != TICK_MAX) tick_in = tick_ff + 1'b1;
                  ec_in = ec_new;
               end
            endcase
         end
      end
      if (cmd.store_freq) begin
         for (int i = 0; i < 3; i++)
            if (rd_idx == 2'(i)) rd_in[i] = (tick_ff == '0) ? '0 : quo_sat;
      end
      if (cmd.chan) begin
         if (fi_ff < 2'd2) begin
            fi_in    = fi_ff + 1'b1;
            phase_in = {cal, STG_SETTLE};
            wait_in  = '0;
         end else if (!cal) begin
            phase_in = PH_IDLE;
         end else begin
            for (int i = 0; i < 3; i++) begin
               sum_w      = {1'b0, sums_ff[i]} + (SUM_W+1)'(rd_ff[i]);
               sums_in[i] = sum_w[SUM_W] ? SUM_MAX : sum_w[SUM_W-1:0];
            end
            if (sts.cal_last) begin
               phase_in = PH_IDLE;
            end else begin
               si_in    = si_ff + 1'b1;
               phase_in = {1'b1, STG_GAP};
               wait_in  = '0;
            end
         end
      end
      if (cmd.store_ref) begin
         for (int i = 0; i < 3; i++)
            if (cmd.idx == 3'(i)) refs_in[i] = avg_ref;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= 2'd0;
         ppr_ff   <= PPR_W'(100);
         stcls_ff <= WAIT_W'(200000);
         stcal_ff <= WAIT_W'(50000);
         gap_ff   <= WAIT_W'(100000);
         phase_ff <= PH_IDLE;
         fi_ff    <= 2'd0;
         last_ff  <= 1'b0;
         ec_ff    <= '0;
         tick_ff  <= '0;
         wait_ff  <= '0;
         si_ff    <= '0;
         for (int i = 0; i < 3; i++) begin
            sums_ff[i] <= '0;
            refs_ff[i] <= FREQ_W'(1);
            rd_ff[i]   <= '0;
         end
      end else begin
         scale_ff <= scale_in;
         ppr_ff   <= ppr_in;
         stcls_ff <= stcls_in;
         stcal_ff <= stcal_in;
         gap_ff   <= gap_in;
         phase_ff <= phase_in;
         fi_ff    <= fi_in;
         last_ff  <= last_in;
         ec_ff    <= ec_in;
         tick_ff  <= tick_in;
         wait_ff  <= wait_in;
         si_ff    <= si_in;
         for (int i = 0; i < 3; i++) begin
            sums_ff[i] <= sums_in[i];
            refs_ff[i] <= refs_in[i];
            rd_ff[i]   <= rd_in[i];
         end
      end
      ppr_hz_ff <= ppr_hz_in;
      if (cmd.mul_en) begin
         for (int i = 0; i < 6; i++)
            if (cmd.idx == 3'(i)) prod_ff[i] <= ma * mb;
      end
      if (cmd.cls_en) cls_ff <= cls_in;
      if (cmd.load_out) begin
         o_scale_ff  <= scale_code(scale_ff);
         o_filter_ff <= filter_code(fi_ff);
         o_busy_ff   <= !idle;
         o_valid_ff  <= cmd.out_sel != OUT_NONE;
         o_kind_ff   <= cmd.out_sel == OUT_CAL;
         o_cls_ff    <= (cmd.out_sel == OUT_CLS) ? cls_ff : 3'd0;
         for (int i = 0; i < 3; i++) begin
            unique case (cmd.out_sel)
               OUT_CLS: o_res_ff[i] <= rd_ff[i];
               OUT_CAL: o_res_ff[i] <= refs_ff[i];
               default: o_res_ff[i] <= '0;
            endcase
         end
      end
   end

   assign rsp_scale_pins   = o_scale_ff;
   assign rsp_filter_pins  = o_filter_ff;
   assign rsp_busy_res     = o_busy_ff;
   assign rsp_result_valid = o_valid_ff;
   assign rsp_result_kind  = o_kind_ff;
   assign rsp_color_class  = o_cls_ff;
   assign rsp_red_freq     = o_res_ff[0];
   assign rsp_green_freq   = o_res_ff[1];
   assign rsp_blue_freq    = o_res_ff[2];

endmodule

[src/cscl_ctrl.sv]
module cscl_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output cscl_pkg::cscl_cmd_type cmd,
   input  cscl_pkg::cscl_sts_type sts
);
   import cscl_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_OUT    = 4'd1;
   localparam logic [3:0] S_FSTART = 4'd2;
   localparam logic [3:0] S_FWAIT  = 4'd3;
   localparam logic [3:0] S_CHAN   = 4'd4;
   localparam logic [3:0] S_MUL    = 4'd5;
   localparam logic [3:0] S_CLS    = 4'd6;
   localparam logic [3:0] S_AVG    = 4'd7;
   localparam logic [3:0] S_OUTC   = 4'd9;
   localparam logic [3:0] S_OUTK   = 4'd10;

   logic [3:0] state_ff, state_in;
   logic [2:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic       out_free, accept;

   assign out_free  = !valid_ff || !rsp_stall;
   assign req_stall = state_ff != S_IDLE;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = valid_ff;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      valid_in = valid_ff && rsp_stall;
      cmd      = '0;
      cmd.idx  = idx_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.step = 1'b1;
               priority if (sts.need_div) state_in = S_FSTART;
               else if (sts.chan_done)    state_in = S_CHAN;
               else                       state_in = S_OUT;
            end
         end
         S_FSTART: begin
            cmd.div_start = 1'b1;
            state_in      = S_FWAIT;
         end
         S_FWAIT: begin
            if (sts.div_done) begin
               cmd.store_freq = 1'b1;
               state_in       = S_CHAN;
            end
         end
         S_CHAN: begin
            cmd.chan = 1'b1;
            idx_in   = 3'd0;
            priority if (!sts.last_chan) state_in = S_OUT;
            else if (!sts.cal)           state_in = S_MUL;
            else if (sts.cal_last)       state_in = S_AVG;
            else                         state_in = S_OUT;
         end
         S_MUL: begin
            cmd.mul_en = 1'b1;
            idx_in     = idx_ff + 1'b1;
            if (idx_ff == 3'd5) state_in = S_CLS;
         end
         S_CLS: begin
            cmd.cls_en = 1'b1;
            state_in   = S_OUTC;
         end
         S_AVG: begin
            cmd.store_ref = 1'b1;
            idx_in        = idx_ff + 1'b1;
            if (idx_ff == 3'd2) state_in = S_OUTK;
         end
         S_OUT, S_OUTC, S_OUTK: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               priority if (state_ff == S_OUTC) cmd.out_sel = OUT_CLS;
               else if (state_ff == S_OUTK)     cmd.out_sel = OUT_CAL;
               else                             cmd.out_sel = OUT_NONE;
               valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> out_free)
      else $error("output word overwritten while stalled");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != S_IDLE)
      else $error("accepted word not processed");

   a_mul_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL && idx_ff == 3'd5) |=> state_ff == S_CLS)
      else $error("product sweep did not end in classify");

endmodule

[src/color_sensor_measure_classify.sv]
// Color sensor measurement and classification.
// Input channel (req_): one word per timer tick, carrying the sampled sensor
// pin level and a command (tick only, start white calibration, start one
// classification). Output channel (rsp_): exactly one word per input word,
// giving the scale and filter pins, busy flag and, on the tick a measurement
// completes, the result (class and three frequencies, or new white refs).
// Configuration (csr_): register index and data, written when valid and ready;
// write only while no word is in flight.
// A plain tick goes from acceptance directly to the output word. A tick
// ending a channel reading first runs the serial divider (NW is the bit
// width of 1023*TICK_HZ, 30 at the default). A classification end then forms
// six cross products on the shared 20x20 multiplier; a calibration end forms
// one reciprocal-multiply average per color. The next word is accepted once
// the output word is loaded. Reset sets control, measurement and config state
// to defaults; white references reset to 1. A stalled output word holds;
// one more input word can be accepted; its output waits for the stalled one.
module color_sensor_measure_classify #(
   parameter int TICK_HZ     = 1000000,
   parameter int CAL_SAMPLES = 5,
   parameter int TICK_WIDTH  = 24
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_func,
   input  logic                            req_sensor_level,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [1:0]                      rsp_scale_pins,
   output logic [1:0]                      rsp_filter_pins,
   output logic                            rsp_busy_res,
   output logic                            rsp_result_valid,
   output logic                            rsp_result_kind,
   output logic [2:0]                      rsp_color_class,
   output logic [cscl_pkg::FREQ_W-1:0]     rsp_red_freq,
   output logic [cscl_pkg::FREQ_W-1:0]     rsp_green_freq,
   output logic [cscl_pkg::FREQ_W-1:0]     rsp_blue_freq,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [cscl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [cscl_pkg::CSR_DAT_W-1:0]  csr_wdata
);
   import cscl_pkg::*;

   cscl_cmd_type cmd;
   cscl_sts_type sts;

   assign csr_ready = 1'b1;

   cscl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   cscl_dp #(
      .TICK_HZ     (TICK_HZ),
      .CAL_SAMPLES (CAL_SAMPLES),
      .TICK_WIDTH  (TICK_WIDTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_func         (req_func),
      .req_sensor_level (req_sensor_level),
      .csr_we           (csr_valid && csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_scale_pins   (rsp_scale_pins),
      .rsp_filter_pins  (rsp_filter_pins),
      .rsp_busy_res     (rsp_busy_res),
      .rsp_result_valid (rsp_result_valid),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_color_class  (rsp_color_class),
      .rsp_red_freq     (rsp_red_freq),
      .rsp_green_freq   (rsp_green_freq),
      .rsp_blue_freq    (rsp_blue_freq)
   );

endmodule

[tb/tb_color_sensor_measure_classify.sv]
module tb_color_sensor_measure_classify;
   import cscl_pkg::*;

   localparam longint unsigned TICK_RATE = 1000000;
   localparam int              AVG_COUNT = 5;

   typedef struct packed {
      logic [1:0]        scale;
      logic [1:0]        filter;
      logic              busy;
      logic              done;
      logic              kind;
      logic [2:0]        cls;
      logic [FREQ_W-1:0] red;
      logic [FREQ_W-1:0] green;
      logic [FREQ_W-1:0] blue;
   } sensor_word_type;

   class color_scoreboard;
      bit [1:0]          scale_mode;
      bit [PPR_W-1:0]    ppr;
      bit [WAIT_W-1:0]   settle_cls, settle_cal, gap_cal;
      bit [2:0]          phase;
      bit [1:0]          fidx;
      bit                last_lvl;
      bit [PPR_W-1:0]    edges;
      bit [WAIT_W-1:0]   ticks, waits;
      bit [2:0]          sample;
      longint unsigned   sums[3], refs[3], rd[3];
      sensor_word_type   pending[$];
      int                errors;

      function new();
         scale_mode = 0; ppr = 100; settle_cls = 200000; settle_cal = 50000;
         gap_cal = 100000; phase = PH_IDLE; fidx = 0; last_lvl = 0;
         edges = 0; ticks = 0; waits = 0; sample = 0; errors = 0;
         for (int i = 0; i < 3; i++) begin
            sums[i] = 0; refs[i] = 1; rd[i] = 0;
         end
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] d);
         case (idx)
            REG_SCALE:      scale_mode = d[1:0];
            REG_PPR:        ppr = d[PPR_W-1:0];
            REG_SETTLE_CLS: settle_cls = d;
            REG_SETTLE_CAL: settle_cal = d;
            REG_GAP_CAL:    gap_cal = d;
            default: ;
         endcase
      endfunction

      function bit ratio_gt(longint unsigned a, longint unsigned ca, longint unsigned ka,
                            longint unsigned b, longint unsigned cb, longint unsigned kb);
         return a * cb * ka > b * ca * kb;
      endfunction

      function logic [2:0] classify();
         longint unsigned r, g, b, cr, cg, cb;
         r = rd[0]; g = rd[1]; b = rd[2];
         cr = refs[0]; cg = refs[1]; cb = refs[2];
         if (ratio_gt(r, cr, 10, g, cg, 20) && ratio_gt(r, cr, 10, b, cb, 18)) return CLS_RED;
         if (ratio_gt(g, cg, 10, r, cr, 16) && ratio_gt(g, cg, 10, b, cb, 15))
            return CLS_GREEN;
         if (ratio_gt(b, cb, 10, r, cr, 18) && ratio_gt(b, cb, 10, g, cg, 17)) return CLS_BLUE;
         if (10 * r < cr && 10 * g < cg && 10 * b < cb) return CLS_BLACK;
         if (10 * r > 9 * cr && 10 * g > 9 * cg && 10 * b > 9 * cb) return CLS_WHITE;
         return CLS_UNDET;
      endfunction

      function void next_channel(bit [1:0] ch);
         fidx = ch;
         phase = {phase[2], STG_SETTLE};
         waits = 0;
      endfunction

      function void note(logic [1:0] f, logic lvl);
         bit              edg, chdone, cal;
         logic [1:0]      stg;
         longint unsigned fq, lim, s;
         sensor_word_type w;
         edg = lvl && !last_lvl;
         chdone = 0;
         cal = phase[2];
         stg = phase[1:0];
         w = '0;
         if (phase == PH_IDLE) begin
            if (f == FUNC_CAL || f == FUNC_CLS) begin
               phase = (f == FUNC_CAL) ? 3'b100 : PH_IDLE;
               sample = 0;
               if (f == FUNC_CAL)
                  for (int i = 0; i < 3; i++) sums[i] = 0;
               next_channel(0);
            end
         end else if (stg == STG_GAP) begin
            if (waits >= gap_cal) next_channel(0);
            else waits++;
         end else if (stg == STG_SETTLE) begin
            lim = cal ? settle_cal : settle_cls;
            if (waits >= lim) phase = {phase[2], STG_FIRST};
            else waits++;
         end else if (stg == STG_FIRST) begin
            if (ppr == 0) begin
               rd[fidx] = 0;
               chdone = 1;
            end else if (edg) begin
               phase = {phase[2], STG_COUNT};
               edges = 0;
               ticks = 0;
            end
         end else begin
            if (ticks != {WAIT_W{1'b1}}) ticks++;
            if (edg) edges++;
            if (edges >= ppr) begin
               fq = (ticks != 0) ? longint'(ppr) * TICK_RATE / ticks : 0;
               if (fq > FREQ_MAX) fq = FREQ_MAX;
               rd[fidx] = fq;
               chdone = 1;
            end
         end
         if (chdone) begin
            if (fidx < 2) begin
               next_channel(2'(fidx + 1));
            end else if (!cal) begin
               phase = PH_IDLE;
               w.done = 1; w.kind = 0; w.cls = classify();
               w.red = FREQ_W'(rd[0]); w.green = FREQ_W'(rd[1]); w.blue = FREQ_W'(rd[2]);
            end else begin
               for (int i = 0; i < 3; i++) begin
                  s = sums[i] + rd[i];
                  sums[i] = (s > SUM_MAX) ? SUM_MAX : s;
               end
               if (sample + 1 >= AVG_COUNT) begin
                  for (int i = 0; i < 3; i++) begin
                     s = sums[i] / AVG_COUNT;
                     if (s > FREQ_MAX) s = FREQ_MAX;
                     refs[i] = (s != 0) ? s : 1;
                  end
                  phase = PH_IDLE;
                  w.done = 1; w.kind = 1; w.cls = CLS_RED;
                  w.red = FREQ_W'(refs[0]); w.green = FREQ_W'(refs[1]);
                  w.blue = FREQ_W'(refs[2]);
               end else begin
                  sample++;
                  phase = {1'b1, STG_GAP};
                  waits = 0;
               end
            end
         end
         last_lvl = lvl;
         case (scale_mode)
            2'd0: w.scale = 2'd2;
            2'd1: w.scale = 2'd1;
            2'd2: w.scale = 2'd3;
            default: w.scale = 2'd0;
         endcase
         case (fidx)
            2'd1: w.filter = 2'd3;
            2'd2: w.filter = 2'd2;
            default: w.filter = 2'd0;
         endcase
         w.busy = (phase != PH_IDLE);
         pending.push_back(w);
      endfunction

      task report(string field, longint unsigned got, longint unsigned exp);
         errors++;
         $display("mismatch %s: got %0d expected %0d", field, got, exp);
      endtask

      task check(sensor_word_type got);
         sensor_word_type e;
         if (pending.size() == 0) begin
            report("unexpected word", 1, 0);
            return;
         end
         e = pending.pop_front();
         if (got.scale !== e.scale) report("scale_pins", got.scale, e.scale);
         if (got.filter !== e.filter) report("filter_pins", got.filter, e.filter);
         if (got.busy !== e.busy) report("busy_res", got.busy, e.busy);
         if (got.done !== e.done) report("result_valid", got.done, e.done);
         if (got.kind !== e.kind) report("result_kind", got.kind, e.kind);
         if (got.cls !== e.cls) report("color_class", got.cls, e.cls);
         if (got.red !== e.red) report("red_freq", got.red, e.red);
         if (got.green !== e.green) report("green_freq", got.green, e.green);
         if (got.blue !== e.blue) report("blue_freq", got.blue, e.blue);
      endtask
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [1:0]           req_func = FUNC_TICK;
   logic                 req_sensor_level = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [1:0]           rsp_scale_pins, rsp_filter_pins;
   logic                 rsp_busy_res, rsp_result_valid, rsp_result_kind;
   logic [2:0]           rsp_color_class;
   logic [FREQ_W-1:0]    rsp_red_freq, rsp_green_freq, rsp_blue_freq;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = REG_SCALE;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;

   color_scoreboard sb = new();
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_reqs = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int n_items = 0;
   int wave = 0;
   int per[3];

   color_sensor_measure_classify u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_func(req_func), .req_sensor_level(req_sensor_level),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_scale_pins(rsp_scale_pins), .rsp_filter_pins(rsp_filter_pins),
      .rsp_busy_res(rsp_busy_res), .rsp_result_valid(rsp_result_valid),
      .rsp_result_kind(rsp_result_kind), .rsp_color_class(rsp_color_class),
      .rsp_red_freq(rsp_red_freq), .rsp_green_freq(rsp_green_freq),
      .rsp_blue_freq(rsp_blue_freq),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(negedge clock) begin
      if (hold_seen != hold_reqs) begin
         hold_seen = hold_reqs;
         hold_left = 400;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check({rsp_scale_pins, rsp_filter_pins, rsp_busy_res, rsp_result_valid,
                   rsp_result_kind, rsp_color_class, rsp_red_freq, rsp_green_freq,
                   rsp_blue_freq});
   end

   task automatic send_word(logic [1:0] f, logic lvl);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_func <= f;
      req_sensor_level <= lvl;
      do @(posedge clock); while (req_stall);
      sb.note(f, lvl);
      n_items++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] d);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(idx, d);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   function automatic int pick_period();
      int opts[8] = '{2, 3, 4, 5, 6, 8, 12, 30};
      return opts[$urandom_range(7)];
   endfunction

   // square wave per channel, low half first, with rare glitches and stray commands
   task automatic run_measure(logic [1:0] cmd, bit new_periods);
      logic       lvl;
      logic [1:0] f;
      int         cnt;
      int         p;
      if (new_periods)
         for (int i = 0; i < 3; i++) per[i] = pick_period();
      send_word(cmd, 1'b0);
      cnt = 0;
      while (sb.phase != PH_IDLE && cnt < 4000) begin
         p = per[sb.fidx % 3];
         lvl = ((wave % p) >= p / 2);
         if ($urandom_range(99) < 3) lvl = 1'($urandom_range(1));
         f = ($urandom_range(99) < 6) ? 2'($urandom_range(3)) : FUNC_TICK;
         send_word(f, lvl);
         wave++;
         cnt++;
      end
   endtask

   initial begin
      #20000000;
      $display("[color_sensor_measure_classify] ERROR");
      $finish;
   end

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      write_reg(REG_SCALE, 24'd3);
      write_reg(REG_PPR, 24'd1023);
      write_reg(REG_SETTLE_CLS, 24'hFFFFFF);
      write_reg(REG_SETTLE_CAL, 24'hFFFFFF);
      write_reg(REG_GAP_CAL, 24'hFFFFFF);
      send_word(FUNC_TICK, 1'b0);
      send_word(FUNC_TICK, 1'b1);
      send_word(2'd3, 1'b0);
      send_word(2'd3, 1'b1);
      drain();
      write_reg(REG_PPR, 24'd0);
      write_reg(REG_SETTLE_CLS, 24'd0);
      write_reg(REG_SETTLE_CAL, 24'd0);
      write_reg(REG_GAP_CAL, 24'd0);
      // zero readings: references fall back to one, then a black classification
      run_measure(FUNC_CAL, 1'b1);
      run_measure(FUNC_CLS, 1'b1);
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 51; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 51; end
            default: begin send_idle_pct = 29; stall_pct = 29; end
         endcase
         write_reg(REG_SCALE, 24'(ph));
         write_reg(REG_PPR, (ph == 3) ? 24'($urandom_range(1, 3)) : 24'(ph + 1));
         write_reg(REG_SETTLE_CLS, (ph == 0) ? 24'd0 : 24'($urandom_range(4)));
         write_reg(REG_SETTLE_CAL, (ph == 0) ? 24'd0 : 24'($urandom_range(4)));
         write_reg(REG_GAP_CAL, (ph == 0) ? 24'd0 : 24'($urandom_range(3)));
         if (ph == 2) hold_reqs++;
         run_measure(FUNC_CAL, 1'b1);
         while (n_items < 470 * (ph + 1)) begin
            if ($urandom_range(99) < 15) begin
               repeat ($urandom_range(1, 6))
                  send_word(2'($urandom_range(3)), 1'($urandom_range(1)));
               if (sb.phase != PH_IDLE) run_measure(FUNC_TICK, 1'b0);
            end else begin
               run_measure(FUNC_CLS, $urandom_range(99) < 70);
            end
         end
         drain();
      end

      repeat (200) @(negedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("[color_sensor_measure_classify] OK");
      else
         $display("[color_sensor_measure_classify] ERROR");
      $finish;
   end

endmodule
